>>> rtl/hrhp_pkg.sv
// ----------------------------------------------------------------------------
// hrhp_pkg
// Shared types, codes and character classes for the request head parser.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrhp_pkg;

  // configuration port geometry
  localparam int CfgAddrBits = 4;
  localparam int CfgDataBits = 32;

  // register indexes (paddr word offset)
  localparam logic [1:0] REG_METHOD_LIMIT  = 2'd0;
  localparam logic [1:0] REG_PATH_LIMIT    = 2'd1;
  localparam logic [1:0] REG_VERSION_LIMIT = 2'd2;
  localparam logic [1:0] REG_HEADER_LIMIT  = 2'd3;

  // limit reset values
  localparam logic [7:0]  METHOD_LIMIT_RST  = 8'd7;
  localparam logic [15:0] PATH_LIMIT_RST    = 16'd2000;
  localparam logic [7:0]  VERSION_LIMIT_RST = 8'd8;
  localparam logic [15:0] HEADER_LIMIT_RST  = 16'd1000;

  // special characters
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  typedef enum logic [3:0] {
    PH_METHOD      = 4'd0,
    PH_PATH        = 4'd1,
    PH_VERSION     = 4'd2,
    PH_EOL_VERSION = 4'd3,
    PH_NAME        = 4'd4,
    PH_VALUE       = 4'd5,
    PH_EOL_VALUE   = 4'd6
  } phase_t;

  typedef enum logic [3:0] {
    EV_TAKEN       = 4'd0,
    EV_METHOD_END  = 4'd1,
    EV_PATH_END    = 4'd2,
    EV_VERSION_END = 4'd3,
    EV_NAME_END    = 4'd4,
    EV_VALUE_END   = 4'd5,
    EV_DONE        = 4'd6,
    EV_BAD         = 4'd7,
    EV_TOO_LARGE   = 4'd8,
    EV_IGNORED     = 4'd9
  } event_t;

  typedef enum logic [2:0] {
    PART_METHOD  = 3'd0,
    PART_PATH    = 3'd1,
    PART_VERSION = 3'd2,
    PART_NAME    = 3'd3,
    PART_VALUE   = 3'd4,
    PART_NONE    = 3'd5
  } part_t;

  // one received byte
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_req;
  } req_t;

  // one parser report
  typedef struct packed {
    event_t      event_res;
    part_t       part;
    logic [15:0] token_length;
    logic [7:0]  byte_echo;
  } res_t;

  // letters and digits
  function automatic logic is_alnum(input logic [7:0] b);
    return (b inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]});
  endfunction

  // punctuation allowed in a request path
  function automatic logic is_path_char(input logic [7:0] b);
    return (b inside {8'h21, [8'h23:8'h2F], 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40,
                      8'h5B, 8'h5D, 8'h5F, 8'h7E});
  endfunction

  // punctuation allowed in header names and values (space included)
  function automatic logic is_head_char(input logic [7:0] b);
    return (b inside {[8'h20:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]});
  endfunction

endpackage

>>> rtl/http_request_head_parser_core.sv
// ----------------------------------------------------------------------------
// http_request_head_parser_core
// Byte-at-a-time checker for an HTTP/1.1 request head. Each byte is tested
// against the character class and length limit of the part it falls in
// (method, path, version, header name, header value) and one report comes
// back per byte: byte taken, token end, head done, bad request, too large or
// ignored, with the token length and the byte itself for downstream capture.
// Throughput is one byte per clock while out_stall is low; a byte's report
// is presented after the byte passes the input register, then the result
// register, and the only loop is the phase/position update done between
// them. The input register lets a new request in while a finished report
// still waits on out_stall. Set start_req on the first byte of each request;
// after head done, bad or too large every byte is ignored until the next
// start_req. Limit registers sit at byte addresses 0, 4, 8, 12 and must be
// written only while the parser is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module http_request_head_parser_core
  import hrhp_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // byte stream in
  input  logic                   in_valid,
  output logic                   in_stall,
  input  req_t                   in_data,
  // reports out
  output logic                   out_valid,
  input  logic                   out_stall,
  output res_t                   out_data,
  // limit registers
  input  logic                   cfg_psel,
  input  logic                   cfg_penable,
  input  logic                   cfg_pwrite,
  input  logic [CfgAddrBits-1:0] cfg_paddr,
  input  logic [CfgDataBits-1:0] cfg_pwdata,
  output logic [CfgDataBits-1:0] cfg_prdata,
  output logic                   cfg_pready
);

  localparam int CmpBits = (POSITION_BITS > 16) ? POSITION_BITS : 16;
  localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};
  localparam logic [POSITION_BITS-1:0] PosOne = {{(POSITION_BITS-1){1'b0}}, 1'b1};

  logic [7:0]  method_limit_r;
  logic [15:0] path_limit_r;
  logic [7:0]  version_limit_r;
  logic [15:0] header_limit_r;

  logic in_valid_r;
  req_t in_data_r;
  logic out_valid_r;
  res_t out_data_r;

  phase_t                   phase_r, phase_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [7:0]               prev_r, prev_nxt;
  logic                     fin_r, fin_nxt;
  res_t                     res_nxt;

  logic                     out_free;
  logic                     advance;
  logic                     cfg_wr;
  logic [7:0]               b;
  logic                     eol;
  logic                     sp;
  phase_t                   cur_phase, work_phase;
  logic [POSITION_BITS-1:0] cur_pos, work_pos;
  logic [7:0]               cur_prev;
  logic                     cur_fin;
  logic                     in_eol_phase;
  logic [CmpBits-1:0]       lim_sel;
  logic                     beyond;
  logic                     is_bad;
  part_t                    bad_part;

  // handshake: input register feeds the result register
  assign out_free   = !out_valid_r || !out_stall;
  assign advance    = in_valid_r && out_free;
  assign in_stall   = in_valid_r && !out_free;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_limit_r  <= METHOD_LIMIT_RST;
      path_limit_r    <= PATH_LIMIT_RST;
      version_limit_r <= VERSION_LIMIT_RST;
      header_limit_r  <= HEADER_LIMIT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_METHOD_LIMIT:  method_limit_r  <= cfg_pwdata[7:0];
        REG_PATH_LIMIT:    path_limit_r    <= cfg_pwdata[15:0];
        REG_VERSION_LIMIT: version_limit_r <= cfg_pwdata[7:0];
        REG_HEADER_LIMIT:  header_limit_r  <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_paddr[3:2])
      REG_METHOD_LIMIT:  cfg_prdata = {24'd0, method_limit_r};
      REG_PATH_LIMIT:    cfg_prdata = {16'd0, path_limit_r};
      REG_VERSION_LIMIT: cfg_prdata = {24'd0, version_limit_r};
      REG_HEADER_LIMIT:  cfg_prdata = {16'd0, header_limit_r};
      default:           cfg_prdata = '0;
    endcase
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // parser state, updated as a request moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_METHOD;
      pos_r   <= '0;
      prev_r  <= 8'd0;
      fin_r   <= 1'b0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      prev_r  <= prev_nxt;
      fin_r   <= fin_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= res_nxt;
    end
  end

  // state as seen by this byte, after a restart
  assign b         = in_data_r.data_byte;
  assign eol       = (b == CH_CR) || (b == CH_LF);
  assign sp        = (b == CH_SP);
  assign cur_phase = in_data_r.start_req ? PH_METHOD : phase_r;
  assign cur_pos   = in_data_r.start_req ? '0 : pos_r;
  assign cur_prev  = in_data_r.start_req ? 8'd0 : prev_r;
  assign cur_fin   = in_data_r.start_req ? 1'b0 : fin_r;

  // a line ending that is not an LF pair falls into a fresh header name
  assign in_eol_phase = (cur_phase == PH_EOL_VERSION) || (cur_phase == PH_EOL_VALUE);
  assign work_phase   = in_eol_phase ? PH_NAME : cur_phase;
  assign work_pos     = in_eol_phase ? '0 : cur_pos;

  // length limit of the current part
  always_comb begin
    case (work_phase)
      PH_METHOD:  lim_sel = CmpBits'(method_limit_r);
      PH_PATH:    lim_sel = CmpBits'(path_limit_r);
      PH_VERSION: lim_sel = CmpBits'(version_limit_r);
      default:    lim_sel = CmpBits'(header_limit_r);
    endcase
  end

  assign beyond = (CmpBits'(work_pos) > lim_sel) || (work_pos == PosMax);

  // part reported with a bad byte
  always_comb begin
    case (work_phase)
      PH_METHOD:  bad_part = PART_METHOD;
      PH_PATH:    bad_part = PART_PATH;
      PH_VERSION: bad_part = PART_VERSION;
      PH_NAME:    bad_part = PART_NAME;
      default:    bad_part = PART_NONE;
    endcase
  end

  // per-byte parse decision
  always_comb begin
    phase_nxt            = work_phase;
    pos_nxt              = work_pos;
    prev_nxt             = cur_prev;
    fin_nxt              = cur_fin;
    is_bad               = 1'b0;
    res_nxt.event_res    = EV_TAKEN;
    res_nxt.part         = PART_NONE;
    res_nxt.token_length = 16'(work_pos);
    res_nxt.byte_echo    = b;

    if (cur_fin) begin
      phase_nxt            = cur_phase;
      pos_nxt              = cur_pos;
      res_nxt.event_res    = EV_IGNORED;
      res_nxt.token_length = 16'd0;
    end else if (in_eol_phase && (b == CH_LF) && (cur_prev == CH_CR)) begin
      // LF closing a CR LF pair
      prev_nxt             = b;
      res_nxt.token_length = 16'd0;
    end else if (in_eol_phase && (b == CH_LF) && (cur_prev == CH_LF)) begin
      // two bare LFs: blank line
      phase_nxt            = cur_phase;
      fin_nxt              = 1'b1;
      res_nxt.event_res    = EV_DONE;
      res_nxt.token_length = 16'd0;
    end else begin
      case (work_phase)
        PH_METHOD: begin
          if (beyond || !(is_alnum(b) || sp) || (sp && work_pos == '0)) begin
            is_bad = 1'b1;
          end else if (sp) begin
            phase_nxt         = PH_PATH;
            pos_nxt           = '0;
            prev_nxt          = b;
            res_nxt.event_res = EV_METHOD_END;
            res_nxt.part      = PART_METHOD;
          end else begin
            pos_nxt      = work_pos + PosOne;
            prev_nxt     = b;
            res_nxt.part = PART_METHOD;
          end
        end
        PH_PATH: begin
          if (beyond || !(is_alnum(b) || is_path_char(b) || sp)
              || (sp && work_pos == '0)) begin
            is_bad = 1'b1;
          end else if (sp) begin
            phase_nxt         = PH_VERSION;
            pos_nxt           = '0;
            prev_nxt          = b;
            res_nxt.event_res = EV_PATH_END;
            res_nxt.part      = PART_PATH;
          end else begin
            pos_nxt      = work_pos + PosOne;
            prev_nxt     = b;
            res_nxt.part = PART_PATH;
          end
        end
        PH_VERSION: begin
          if (beyond || !(is_alnum(b) || b == CH_SLASH || b == CH_DOT || eol)
              || (eol && work_pos == '0)) begin
            is_bad = 1'b1;
          end else if (eol) begin
            phase_nxt         = PH_EOL_VERSION;
            pos_nxt           = '0;
            prev_nxt          = b;
            res_nxt.event_res = EV_VERSION_END;
            res_nxt.part      = PART_VERSION;
          end else begin
            pos_nxt      = work_pos + PosOne;
            prev_nxt     = b;
            res_nxt.part = PART_VERSION;
          end
        end
        PH_NAME: begin
          if (eol && work_pos == '0) begin
            // blank line ends the head
            fin_nxt              = 1'b1;
            res_nxt.event_res    = EV_DONE;
            res_nxt.token_length = 16'd0;
          end else if (beyond) begin
            fin_nxt           = 1'b1;
            res_nxt.event_res = EV_TOO_LARGE;
            res_nxt.part      = PART_NAME;
          end else if (!(is_alnum(b) || is_head_char(b))
                       || (sp && (work_pos == '0 || cur_prev != CH_COLON))) begin
            is_bad = 1'b1;
          end else if (sp) begin
            // colon space: name length excludes the colon
            phase_nxt            = PH_VALUE;
            pos_nxt              = '0;
            prev_nxt             = b;
            res_nxt.event_res    = EV_NAME_END;
            res_nxt.part         = PART_NAME;
            res_nxt.token_length = 16'(work_pos - PosOne);
          end else begin
            pos_nxt      = work_pos + PosOne;
            prev_nxt     = b;
            res_nxt.part = PART_NAME;
          end
        end
        PH_VALUE: begin
          if (beyond) begin
            fin_nxt           = 1'b1;
            res_nxt.event_res = EV_TOO_LARGE;
            res_nxt.part      = PART_VALUE;
          end else if (!(is_alnum(b) || is_head_char(b) || eol)
                       || (eol && work_pos == '0)) begin
            is_bad = 1'b1;
          end else if (eol) begin
            phase_nxt         = PH_EOL_VALUE;
            pos_nxt           = '0;
            prev_nxt          = b;
            res_nxt.event_res = EV_VALUE_END;
            res_nxt.part      = PART_VALUE;
          end else begin
            pos_nxt      = work_pos + PosOne;
            prev_nxt     = b;
            res_nxt.part = PART_VALUE;
          end
        end
        default: begin
          is_bad = 1'b1;
        end
      endcase

      // any rejected byte ends the request
      if (is_bad) begin
        phase_nxt            = work_phase;
        pos_nxt              = work_pos;
        prev_nxt             = cur_prev;
        fin_nxt              = 1'b1;
        res_nxt.event_res    = EV_BAD;
        res_nxt.part         = bad_part;
        res_nxt.token_length = 16'(work_pos);
      end
    end
  end

  // a request after finish without restart reports ignored
  a_ignored_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    advance && fin_r && !in_data_r.start_req
    |=> out_valid_r && out_data_r.event_res == EV_IGNORED)
    else $error("finished parser did not ignore a request");

  // finish only comes with a terminating report
  a_finish_has_report: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(fin_r) |-> out_valid_r && (out_data_r.event_res == EV_DONE ||
                                     out_data_r.event_res == EV_BAD ||
                                     out_data_r.event_res == EV_TOO_LARGE))
    else $error("finish flag set without a terminating report");

  // line ending phases hold no position
  a_eol_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_EOL_VERSION || phase_r == PH_EOL_VALUE) |-> pos_r == '0)
    else $error("position not cleared in line ending phase");

  // the state only moves when a request reaches the result register
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(phase_r) && $stable(pos_r) && $stable(fin_r))
    else $error("parser state changed without a request");

endmodule

>>> dv/tb_http_request_head_parser_core.sv
// ----------------------------------------------------------------------------
// tb_http_request_head_parser_core
// Self-checking bench for the request head parser. Bytes go in over the
// valid/stall channel. Each accepted byte runs through a local copy of the
// parse rules, and the predicted report is queued. The output monitor checks
// every report, field by field, against the oldest queued prediction.
// Traffic is a few hand-built heads, then random heads under several sets of
// limit registers (default, tiny, zero, maximum). Both sides idle in random
// bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_http_request_head_parser_core;
  import hrhp_pkg::*;

  localparam int          STALL_LIMIT = 2000;
  localparam int          POS_CEILING = (1 << 16) - 1;
  localparam logic [7:0]  CH_GRAVE    = 8'h60;
  localparam string ALNUM_CHARS =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
  localparam string PATH_PUNCT    = "-._~:/?#[]@!$&'()*+,;%=";
  // header punctuation; the grave accent is handled on its own
  localparam string HEAD_PUNCT    = "_ :;.,\\/\"'?!(){}[]@<>=-+*#$&|~^%";
  localparam string VERSION_CHARS = "HTP/1.0./";

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  req_t                   in_data;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  res_t                   out_data;
  logic                   cfg_psel;
  logic                   cfg_penable;
  logic                   cfg_pwrite;
  logic [CfgAddrBits-1:0] cfg_paddr;
  logic [CfgDataBits-1:0] cfg_pwdata;
  logic [CfgDataBits-1:0] cfg_prdata;
  logic                   cfg_pready;

  // predicted parser state and limit shadows
  phase_t     pred_phase;
  int         pred_pos;
  logic [7:0] pred_prev;
  bit         pred_finished;
  int         lim_method;
  int         lim_path;
  int         lim_version;
  int         lim_header;

  res_t expected_reports[$];
  int   error_count = 0;
  int   idle_cycles = 0;
  int   bytes_sent  = 0;
  int   stall_left  = 0;
  int   calm_left   = 0;
  bit   quiet_tail  = 1'b0;
  bit   in_calm     = 1'b0;

  http_request_head_parser_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // character classes and limit check
  // ---------------------------------------------------------------------------
  function automatic bit char_in(input string s, input logic [7:0] b);
    for (int i = 0; i < s.len(); i++) begin
      if (s[i] == b) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic bit is_letter_or_digit(input logic [7:0] b);
    return (b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9");
  endfunction

  function automatic bit is_header_char(input logic [7:0] b);
    return is_letter_or_digit(b) || char_in(HEAD_PUNCT, b) || b == CH_GRAVE;
  endfunction

  // a byte at the saturated position is always past the limit
  function automatic bit past_limit(input int p, input int lim);
    return (p > lim) || (p >= POS_CEILING);
  endfunction

  // ---------------------------------------------------------------------------
  // parse rules: one report per accepted request
  // ---------------------------------------------------------------------------
  function automatic res_t predict_report(input req_t r);
    logic [7:0] b;
    int         p;
    bit         eol;
    bit         bad;
    bit         ends;
    event_t     end_ev;
    phase_t     next_phase;
    res_t       o;
    b              = r.data_byte;
    eol            = (b == CH_CR) || (b == CH_LF);
    bad            = 1'b0;
    ends           = 1'b0;
    end_ev         = EV_TAKEN;
    next_phase     = pred_phase;
    o.event_res    = EV_IGNORED;
    o.part         = PART_NONE;
    o.token_length = '0;
    o.byte_echo    = b;
    if (r.start_req) begin
      pred_phase    = PH_METHOD;
      pred_pos      = 0;
      pred_prev     = '0;
      pred_finished = 1'b0;
    end
    if (pred_finished) return o;
    // line end after version or value
    if (pred_phase == PH_EOL_VERSION || pred_phase == PH_EOL_VALUE) begin
      if (b == CH_LF && pred_prev == CH_CR) begin
        pred_phase  = PH_NAME;
        pred_pos    = 0;
        pred_prev   = b;
        o.event_res = EV_TAKEN;
        return o;
      end
      if (b == CH_LF && pred_prev == CH_LF) begin
        pred_finished = 1'b1;
        o.event_res   = EV_DONE;
        return o;
      end
      pred_phase = PH_NAME;
      pred_pos   = 0;
    end
    p              = pred_pos;
    o.token_length = p[15:0];
    case (pred_phase)
      PH_METHOD: begin
        o.part     = PART_METHOD;
        bad        = past_limit(p, lim_method) || !(is_letter_or_digit(b) || b == CH_SP)
                     || (b == CH_SP && p == 0);
        ends       = (b == CH_SP);
        end_ev     = EV_METHOD_END;
        next_phase = PH_PATH;
      end
      PH_PATH: begin
        o.part     = PART_PATH;
        bad        = past_limit(p, lim_path)
                     || !(is_letter_or_digit(b) || char_in(PATH_PUNCT, b) || b == CH_SP)
                     || (b == CH_SP && p == 0);
        ends       = (b == CH_SP);
        end_ev     = EV_PATH_END;
        next_phase = PH_VERSION;
      end
      PH_VERSION: begin
        o.part     = PART_VERSION;
        bad        = past_limit(p, lim_version)
                     || !(is_letter_or_digit(b) || b == CH_SLASH || b == CH_DOT || eol)
                     || (eol && p == 0);
        ends       = eol;
        end_ev     = EV_VERSION_END;
        next_phase = PH_EOL_VERSION;
      end
      PH_NAME: begin
        // blank line ends the head at once
        if (p == 0 && eol) begin
          pred_finished  = 1'b1;
          o.event_res    = EV_DONE;
          o.token_length = '0;
          return o;
        end
        o.part = PART_NAME;
        if (past_limit(p, lim_header)) begin
          pred_finished = 1'b1;
          o.event_res   = EV_TOO_LARGE;
          return o;
        end
        bad        = !is_header_char(b) || (b == CH_SP && (p == 0 || pred_prev != CH_COLON));
        ends       = (b == CH_SP);
        end_ev     = EV_NAME_END;
        next_phase = PH_VALUE;
        // name length leaves out the colon
        if (ends) o.token_length = 16'(p - 1);
      end
      PH_VALUE: begin
        o.part = PART_VALUE;
        if (past_limit(p, lim_header)) begin
          pred_finished = 1'b1;
          o.event_res   = EV_TOO_LARGE;
          return o;
        end
        bad        = !(is_header_char(b) || eol) || (eol && p == 0);
        ends       = eol;
        end_ev     = EV_VALUE_END;
        next_phase = PH_EOL_VALUE;
      end
      default: begin
        bad    = 1'b1;
        o.part = PART_NONE;
      end
    endcase
    if (bad) begin
      pred_finished = 1'b1;
      o.event_res   = EV_BAD;
      // a bad byte in a value is reported with part none
      if (pred_phase == PH_VALUE) o.part = PART_NONE;
    end else if (ends) begin
      pred_phase  = next_phase;
      pred_pos    = 0;
      pred_prev   = b;
      o.event_res = end_ev;
    end else begin
      pred_pos    = p + 1;
      pred_prev   = b;
      o.event_res = EV_TAKEN;
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // failure reporting
  // ---------------------------------------------------------------------------
  task automatic report_failure(input string msg);
    error_count++;
    if (error_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // request driver
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit restart);
    req_t item;
    int   gap;
    item.data_byte = b;
    item.start_req = restart;
    gap = (!quiet_tail && !in_calm && $urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    expected_reports.push_back(predict_report(item));
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == 0);
  endtask

  // drop valid and let every queued report come back
  task automatic wait_for_idle();
    @(negedge clk) in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // register write with read-back
  // ---------------------------------------------------------------------------
  task automatic write_register(input logic [1:0] idx, input int unsigned value);
    logic [31:0] mask;
    logic [31:0] got;
    mask = (idx == REG_PATH_LIMIT || idx == REG_HEADER_LIMIT) ? 32'hFFFF : 32'hFF;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= ($urandom & ~mask) | (value & mask);
    @(negedge clk) cfg_penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_pready) break;
    end
    case (idx)
      REG_METHOD_LIMIT:  lim_method  = value & mask;
      REG_PATH_LIMIT:    lim_path    = value & mask;
      REG_VERSION_LIMIT: lim_version = value & mask;
      REG_HEADER_LIMIT:  lim_header  = value & mask;
      default: ;
    endcase
    // read back the same register
    @(negedge clk);
    cfg_pwrite  <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk) cfg_penable <= 1'b1;
    forever begin
      @(posedge clk);
      if (cfg_pready) break;
    end
    got = cfg_prdata;
    if (got !== (value & mask))
      report_failure($sformatf("register %0d read: expected %0h, got %0h",
                               idx, value & mask, got));
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic set_limits(input int m, input int p, input int v, input int h);
    write_register(REG_METHOD_LIMIT, m);
    write_register(REG_PATH_LIMIT, p);
    write_register(REG_VERSION_LIMIT, v);
    write_register(REG_HEADER_LIMIT, h);
  endtask

  // ---------------------------------------------------------------------------
  // random head generation
  // ---------------------------------------------------------------------------
  // token length: mostly legal, sometimes empty or just past the limit
  function automatic int pick_len(input int lim, input int cap);
    int hi;
    if ($urandom_range(0, 15) == 0) return 0;
    if (lim >= 0 && lim < cap && $urandom_range(0, 5) == 0) return lim + 1 + $urandom_range(0, 1);
    hi = (lim < cap) ? lim : cap;
    return (hi < 1) ? 1 : $urandom_range(1, hi);
  endfunction

  function automatic logic [7:0] pick_from(input string s);
    return s[$urandom_range(0, s.len() - 1)];
  endfunction

  function automatic logic [7:0] pick_token_char(input part_t which);
    logic [7:0] b;
    b = pick_from(ALNUM_CHARS);
    case (which)
      PART_PATH:    if ($urandom_range(0, 3) == 0) b = pick_from(PATH_PUNCT);
      PART_VERSION: if ($urandom_range(0, 1) == 0) b = pick_from(VERSION_CHARS);
      PART_NAME: begin
        if ($urandom_range(0, 4) == 0) b = pick_from(HEAD_PUNCT);
        // a space would end or break the name early
        if (b == CH_SP) b = "-";
      end
      PART_VALUE: begin
        if ($urandom_range(0, 3) == 0) b = pick_from(HEAD_PUNCT);
        if ($urandom_range(0, 49) == 0) b = CH_GRAVE;
      end
      default: ;
    endcase
    return b;
  endfunction

  task automatic send_random_head();
    logic [7:0] head[$];
    int         n;
    int         restart_at;
    in_calm = ($urandom_range(0, 3) == 0);
    n = pick_len(lim_method, 10);
    repeat (n) head.push_back(pick_token_char(PART_METHOD));
    head.push_back(CH_SP);
    n = pick_len(lim_path, 24);
    repeat (n) head.push_back(pick_token_char(PART_PATH));
    head.push_back(CH_SP);
    n = pick_len(lim_version, 10);
    repeat (n) head.push_back(pick_token_char(PART_VERSION));
    if ($urandom_range(0, 1)) head.push_back(CH_CR);
    head.push_back(CH_LF);
    repeat ($urandom_range(0, 3)) begin
      n = pick_len(lim_header - 1, 10);
      repeat (n) head.push_back(pick_token_char(PART_NAME));
      head.push_back(CH_COLON);
      head.push_back(CH_SP);
      n = pick_len(lim_header, 12);
      repeat (n) head.push_back(pick_token_char(PART_VALUE));
      if ($urandom_range(0, 1)) head.push_back(CH_CR);
      head.push_back(CH_LF);
    end
    // blank line
    if ($urandom_range(0, 1)) head.push_back(CH_CR);
    head.push_back(CH_LF);
    // trailing byte, corrupted byte, cut-off head
    if ($urandom_range(0, 2) == 0) head.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 4) == 0)
      head[$urandom_range(0, head.size() - 1)] = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 9) == 0) head = head[0:$urandom_range(0, head.size() - 1)];
    // occasional restart in mid-head
    restart_at = ($urandom_range(0, 19) == 0) ? $urandom_range(1, head.size() - 1) : -1;
    foreach (head[i]) send_byte(head[i], i == 0 || i == restart_at);
    in_calm = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // hand-built heads under reset limits
  task automatic test_directed_heads();
    // CRLF after value, other byte after line end, blank CR, byte after finish
    send_text("A / H\nx: y\r\n\r");
    send_byte(8'hFF, 1'b0);
    // bare LF twice ends the head
    send_text("A / H\n\n");
    // empty method
    send_byte(CH_SP, 1'b1);
    // empty path
    send_text("B  ");
    // NUL in method
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_random_traffic(input int m, input int p, input int v, input int h,
                                     input int items);
    wait_for_idle();
    set_limits(m, p, v, h);
    bytes_sent = 0;
    while (bytes_sent < items) send_random_head();
  endtask

  // ---------------------------------------------------------------------------
  // result stall: random bursts with calm stretches, none in the tail
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (quiet_tail) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (calm_left > 0) begin
      out_stall <= 1'b0;
      calm_left--;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall  <= 1'b1;
      stall_left = $urandom_range(0, 14);
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(20, 100);
    end
  end

  // ---------------------------------------------------------------------------
  // report checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_reports
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        report_failure($sformatf("unexpected report ev=%0d part=%0d len=%0d byte=%02h",
                                 out_data.event_res, out_data.part,
                                 out_data.token_length, out_data.byte_echo));
      end else begin
        want = expected_reports.pop_front();
        if (out_data.event_res !== want.event_res || out_data.part !== want.part ||
            out_data.token_length !== want.token_length ||
            out_data.byte_echo !== want.byte_echo)
          report_failure($sformatf(
            "report: expected ev=%0d part=%0d len=%0d byte=%02h, got ev=%0d part=%0d len=%0d byte=%02h",
            want.event_res, want.part, want.token_length, want.byte_echo,
            out_data.event_res, out_data.part, out_data.token_length, out_data.byte_echo));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog on cycles with no handshake
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_psel      = 1'b0;
    cfg_penable   = 1'b0;
    cfg_pwrite    = 1'b0;
    cfg_paddr     = '0;
    cfg_pwdata    = '0;
    pred_phase    = PH_METHOD;
    pred_pos      = 0;
    pred_prev     = '0;
    pred_finished = 1'b0;
    lim_method    = METHOD_LIMIT_RST;
    lim_path      = PATH_LIMIT_RST;
    lim_version   = VERSION_LIMIT_RST;
    lim_header    = HEADER_LIMIT_RST;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_heads();
    test_random_traffic(7, 2000, 8, 1000, 150);
    test_random_traffic(3, 6, 4, 5, 220);
    test_random_traffic(0, 0, 0, 0, 40);
    test_random_traffic(1, 1, 1, 2, 60);
    test_random_traffic(255, 65535, 255, 65535, 150);
    quiet_tail = 1'b1;
    test_random_traffic(5, 12, 8, 9, 230);

    wait_for_idle();
    repeat (8) @(posedge clk);
    if (expected_reports.size() != 0)
      report_failure($sformatf("%0d reports never arrived", expected_reports.size()));
    if (error_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
